/* rtl/request_frame_decoder_assert.svh */
// Assertion macros shared by the request frame decoder RTL.
// Needs no other file; the including module supplies clock and reset names.
`ifndef REQUEST_FRAME_DECODER_ASSERT_SVH
`define REQUEST_FRAME_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is asserted (reset is active low).
`define RFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds while reset is asserted.
`define RFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/rfd_pkg.sv */
`timescale 1ns / 1ps
// Types and constants of the request frame decoder.
// Used by the configuration interface, the parser and the top level.
package rfd_pkg;

    localparam int unsigned FieldBytes   = 4;
    localparam int unsigned MaxResults   = 2;
    localparam int unsigned CfgIdxWidth  = 8;

    localparam logic [31:0] MaxPayloadReset = 32'd1048576;
    localparam logic [31:0] MaxArgsReset    = 32'd64;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_MAX_PAYLOAD = 8'd0,
        CFG_MAX_ARGS    = 8'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        PH_OUTER = 3'd0,
        PH_COUNT = 3'd1,
        PH_ALEN  = 3'd2,
        PH_DATA  = 3'd3,
        PH_SKIP  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HDR    = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RSN_OVERSIZE  = 3'd0,
        RSN_NO_COUNT  = 3'd1,
        RSN_MANY_ARGS = 3'd2,
        RSN_TRUNC_LEN = 3'd3,
        RSN_OVERRUN   = 3'd4,
        RSN_TRAILING  = 3'd5
    } t_reason;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] arg_index;
        logic [31:0] arg_length;
        logic [7:0]  data_byte;
        logic        last_of_arg;
        logic [31:0] total_args;
        t_reason     reject_reason;
        logic        last_result;
    } t_result;

    // Up to two results caused by one input byte.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

    localparam t_result ResultZero = '{
        kind: KIND_HDR, arg_index: 32'd0, arg_length: 32'd0, data_byte: 8'd0,
        last_of_arg: 1'b0, total_args: 32'd0, reject_reason: RSN_OVERSIZE,
        last_result: 1'b0
    };

    function automatic t_result f_reject(input t_reason reason);
        t_result r;
        r = ResultZero;
        r.kind = KIND_REJECT;
        r.reject_reason = reason;
        return r;
    endfunction

endpackage

/* rtl/rfd_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the request frame decoder:
// request bytes, decoded results and configuration writes. Uses rfd_pkg.
interface rfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface rfd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] arg_index;
    logic [31:0] arg_length;
    logic [7:0]  data_byte;
    logic        last_of_arg;
    logic [31:0] total_args;
    logic [2:0]  reject_reason;
    logic        last_result;

    modport source (
        output valid, output kind, output arg_index, output arg_length,
        output data_byte, output last_of_arg, output total_args,
        output reject_reason, output last_result, input ready
    );
    modport sink (
        input valid, input kind, input arg_index, input arg_length,
        input data_byte, input last_of_arg, input total_args,
        input reject_reason, input last_result, output ready
    );
endinterface

interface rfd_cfg_if
    import rfd_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CfgIdxWidth-1:0] index;
    logic [31:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/request_frame_decoder.sv */
`timescale 1ns / 1ps
// Top level of the request frame decoder: configuration registers and
// result buffer. Depends on rfd_pkg, rfd_if, rfd_parser and the assert header.
//
// Usage:
//   i_req carries the raw request stream, one byte per transfer. o_rsp
//   carries the decoded results: argument headers, argument data bytes and
//   one accept or reject per frame; last_result marks the final result that
//   a byte caused. i_cfg writes the payload limit (index CFG_MAX_PAYLOAD)
//   and the argument count limit (index CFG_MAX_ARGS); it is always ready.
//   Each accepted byte is parsed in the cycle of its transfer and its zero,
//   one or two results are registered in a two-entry buffer, so the first
//   result appears in the cycle after the byte. A byte that gives one result
//   sustains one byte per cycle while o_rsp is ready; a two-result byte
//   holds i_req until the buffer, draining one result per cycle, has one left.
//   When o_rsp stalls, the buffer holds its results and i_req is not ready.
//   Synchronous reset empties the buffer, restores the reset limits and
//   returns the parser to the start of a frame. After an oversize reject
//   all bytes are taken and dropped until the next reset.
`include "request_frame_decoder_assert.svh"

module request_frame_decoder
    import rfd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rfd_byte_if.sink     i_req,
    rfd_result_if.source o_rsp,
    rfd_cfg_if.sink      i_cfg
);

    logic [31:0] r_max_payload;
    logic [31:0] r_max_args;
    logic [1:0]  r_cnt;
    t_result     r_res0;
    t_result     r_res1;
    t_step       w_step;
    logic        w_in_ready;
    logic        w_take;
    logic        w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MaxPayloadReset;
            r_max_args    <= MaxArgsReset;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg.data;
                CFG_MAX_ARGS:    r_max_args    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // A new byte may enter when the buffer is empty after this cycle.
    assign w_pop      = (r_cnt != 2'd0) && o_rsp.ready;
    assign w_in_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_rsp.ready);
    assign w_take     = i_req.valid && w_in_ready;
    assign i_req.ready = w_in_ready;

    rfd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_byte        (i_req.in_byte),
        .i_max_payload (r_max_payload),
        .i_max_args    (r_max_args),
        .o_step        (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_take) begin
            r_cnt <= w_step.count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res0 <= w_step.res0;
            r_res1 <= w_step.res1;
        end else if (w_pop) begin
            r_res0 <= r_res1;
        end
    end

    assign o_rsp.valid         = (r_cnt != 2'd0);
    assign o_rsp.kind          = r_res0.kind;
    assign o_rsp.arg_index     = r_res0.arg_index;
    assign o_rsp.arg_length    = r_res0.arg_length;
    assign o_rsp.data_byte     = r_res0.data_byte;
    assign o_rsp.last_of_arg   = r_res0.last_of_arg;
    assign o_rsp.total_args    = r_res0.total_args;
    assign o_rsp.reject_reason = r_res0.reject_reason;
    assign o_rsp.last_result   = r_res0.last_result;

    `RFD_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> !o_rsp.valid,
        "result channel not empty after a reset cycle")
    `RFD_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3,
        "result buffer holds more than two entries")
    `RFD_ASSERT(a_single_is_last, i_clk, i_rst_n, (r_cnt == 2'd1) |-> r_res0.last_result,
        "lone buffered result is not marked last")
    `RFD_ASSERT(a_pair_marks, i_clk, i_rst_n, (w_take && w_step.count == 2'd2)
        |=> (!r_res0.last_result && r_res1.last_result),
        "two-result byte has wrong last marks")

endmodule

/* rtl/rfd_parser.sv */
`timescale 1ns / 1ps
// Frame parser: holds the parse state and computes the results of one byte.
// Depends on rfd_pkg and request_frame_decoder_assert.svh.
`include "request_frame_decoder_assert.svh"

module rfd_parser
    import rfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_max_payload,
    input  logic [31:0] i_max_args,
    output t_step       o_step
);

    t_phase      r_phase,       n_phase;
    logic [1:0]  r_field_cnt,   n_field_cnt;
    logic [31:0] r_field_shift, n_field_shift;
    logic [31:0] r_payload,     n_payload;
    logic [31:0] r_args_exp,    n_args_exp;
    logic [31:0] r_cur_arg,     n_cur_arg;
    logic [31:0] r_arg_left,    n_arg_left;
    t_reason     r_pend_reason, n_pend_reason;
    logic        r_blocked,     n_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_OUTER;
            r_field_cnt   <= 2'd0;
            r_field_shift <= 32'd0;
            r_payload     <= 32'd0;
            r_args_exp    <= 32'd0;
            r_cur_arg     <= 32'd0;
            r_arg_left    <= 32'd0;
            r_pend_reason <= RSN_OVERSIZE;
            r_blocked     <= 1'b0;
        end else if (i_take) begin
            r_phase       <= n_phase;
            r_field_cnt   <= n_field_cnt;
            r_field_shift <= n_field_shift;
            r_payload     <= n_payload;
            r_args_exp    <= n_args_exp;
            r_cur_arg     <= n_cur_arg;
            r_arg_left    <= n_arg_left;
            r_pend_reason <= n_pend_reason;
            r_blocked     <= n_blocked;
        end
    end

    always_comb begin
        logic [31:0] v_shift;
        logic [1:0]  v_fcnt;
        logic        v_done;
        logic        v_pay_last;
        logic        v_fin;
        logic        v_rej;
        t_reason     v_reason;
        logic [31:0] v_arg_next;
        t_result     v_res0;
        t_result     v_res1;
        logic [1:0]  v_cnt;

        n_phase       = r_phase;
        n_field_cnt   = r_field_cnt;
        n_field_shift = r_field_shift;
        n_payload     = r_payload;
        n_args_exp    = r_args_exp;
        n_cur_arg     = r_cur_arg;
        n_arg_left    = r_arg_left;
        n_pend_reason = r_pend_reason;
        n_blocked     = r_blocked;

        v_shift    = {r_field_shift[23:0], i_byte};
        v_fcnt     = r_field_cnt + 2'd1;
        v_done     = (v_fcnt == 2'd0);
        // In every phase that consumes payload at least one byte is left.
        v_pay_last = (r_payload == 32'd1);
        v_fin      = 1'b0;
        v_rej      = 1'b0;
        v_reason   = RSN_OVERSIZE;
        v_arg_next = r_cur_arg + 32'd1;
        v_res0     = ResultZero;
        v_res1     = ResultZero;
        v_cnt      = 2'd0;

        if (!r_blocked) begin
            case (r_phase)
                PH_OUTER: begin
                    n_field_cnt   = v_fcnt;
                    n_field_shift = v_shift;
                    if (v_done) begin
                        n_field_shift = 32'd0;
                        if (v_shift > i_max_payload) begin
                            n_blocked = 1'b1;
                            n_payload = 32'd0;
                            v_rej     = 1'b1;
                            v_reason  = RSN_OVERSIZE;
                        end else begin
                            n_payload = v_shift;
                            if (v_shift == 32'd0) begin
                                v_rej    = 1'b1;
                                v_reason = RSN_NO_COUNT;
                            end else begin
                                n_phase = PH_COUNT;
                            end
                        end
                    end
                end
                PH_COUNT: begin
                    n_payload     = r_payload - 32'd1;
                    n_field_cnt   = v_fcnt;
                    n_field_shift = v_shift;
                    if (v_done) begin
                        n_field_shift = 32'd0;
                        if (v_shift > i_max_args) begin
                            v_rej    = 1'b1;
                            v_reason = RSN_MANY_ARGS;
                        end else begin
                            n_args_exp = v_shift;
                            n_cur_arg  = 32'd0;
                            if (v_shift == 32'd0) begin
                                if (v_pay_last) begin
                                    n_phase     = PH_OUTER;
                                    v_res0.kind = KIND_ACCEPT;
                                    v_cnt       = 2'd1;
                                end else begin
                                    v_rej    = 1'b1;
                                    v_reason = RSN_TRAILING;
                                end
                            end else if (v_pay_last) begin
                                v_rej    = 1'b1;
                                v_reason = RSN_TRUNC_LEN;
                            end else begin
                                n_phase = PH_ALEN;
                            end
                        end
                    end else if (v_pay_last) begin
                        v_rej    = 1'b1;
                        v_reason = RSN_NO_COUNT;
                    end
                end
                PH_ALEN: begin
                    n_payload     = r_payload - 32'd1;
                    n_field_cnt   = v_fcnt;
                    n_field_shift = v_shift;
                    if (v_done) begin
                        n_field_shift = 32'd0;
                        // Length above what is left after this byte.
                        if (v_shift >= r_payload) begin
                            v_rej    = 1'b1;
                            v_reason = RSN_OVERRUN;
                        end else begin
                            v_res0.kind       = KIND_HDR;
                            v_res0.arg_index  = r_cur_arg;
                            v_res0.arg_length = v_shift;
                            v_cnt             = 2'd1;
                            n_arg_left        = v_shift;
                            if (v_shift == 32'd0) begin
                                v_fin = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end else if (v_pay_last) begin
                        v_rej    = 1'b1;
                        v_reason = RSN_TRUNC_LEN;
                    end
                end
                PH_DATA: begin
                    n_payload          = r_payload - 32'd1;
                    n_arg_left         = r_arg_left - 32'd1;
                    v_res0.kind        = KIND_DATA;
                    v_res0.arg_index   = r_cur_arg;
                    v_res0.data_byte   = i_byte;
                    v_res0.last_of_arg = (r_arg_left == 32'd1);
                    v_cnt              = 2'd1;
                    v_fin              = (r_arg_left == 32'd1);
                end
                PH_SKIP: begin
                    n_payload = r_payload - 32'd1;
                    if (v_pay_last) begin
                        n_phase = PH_OUTER;
                    end
                end
                default: begin
                    n_phase       = PH_OUTER;
                    n_field_cnt   = 2'd0;
                    n_field_shift = 32'd0;
                end
            endcase

            // End of an argument: accept, reject, or read the next length.
            if (v_fin) begin
                n_cur_arg = v_arg_next;
                if (v_arg_next == r_args_exp) begin
                    if (v_pay_last) begin
                        n_phase           = PH_OUTER;
                        v_res1.kind       = KIND_ACCEPT;
                        v_res1.total_args = r_args_exp;
                        v_cnt             = 2'd2;
                    end else begin
                        v_rej    = 1'b1;
                        v_reason = RSN_TRAILING;
                    end
                end else if (v_pay_last) begin
                    v_rej    = 1'b1;
                    v_reason = RSN_TRUNC_LEN;
                end else begin
                    n_phase       = PH_ALEN;
                    n_field_cnt   = 2'd0;
                    n_field_shift = 32'd0;
                end
            end

            if (v_rej) begin
                n_pend_reason = v_reason;
                n_phase       = (n_payload != 32'd0) ? PH_SKIP : PH_OUTER;
                n_field_cnt   = 2'd0;
                n_field_shift = 32'd0;
                if (v_cnt == 2'd0) begin
                    v_res0 = f_reject(v_reason);
                end else begin
                    v_res1 = f_reject(v_reason);
                end
                v_cnt = v_cnt + 2'd1;
            end
        end

        if (v_cnt == 2'd1) begin
            v_res0.last_result = 1'b1;
        end
        if (v_cnt == 2'd2) begin
            v_res1.last_result = 1'b1;
        end

        o_step.count = v_cnt;
        o_step.res0  = v_res0;
        o_step.res1  = v_res1;
    end

    `RFD_ASSERT(a_blocked_silent, i_clk, i_rst_n, r_blocked |-> (o_step.count == 2'd0),
        "blocked stream still produces results")
    `RFD_ASSERT(a_payload_left, i_clk, i_rst_n,
        (r_phase == PH_COUNT || r_phase == PH_ALEN || r_phase == PH_SKIP)
        |-> (r_payload != 32'd0),
        "payload-consuming phase with no payload left")
    `RFD_ASSERT(a_arg_fits, i_clk, i_rst_n,
        (r_phase == PH_DATA) |-> (r_arg_left != 32'd0 && r_arg_left <= r_payload),
        "argument bytes exceed remaining payload")

endmodule
